// ===== design/assert_macros.svh =====
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with reset disable.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check with reset disable.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/srsa_pkg.sv =====
package srsa_pkg;

   localparam int MaxRowsDef = 1024;
   localparam int MaxColsDef = 1024;
   localparam int RowCapDef  = 16;

   localparam int CfgW = 11;
   localparam int RowW = 10;
   localparam int ColW = 10;
   localparam int ValW = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ADD    = 2'd1,
      OP_READ   = 2'd2,
      OP_SORT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BOUNDS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_ROWS = 1'd0,
      CSR_COLS = 1'd1
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_SCAN,
      S_WAIT,
      S_UPD,
      S_SORT_LD,
      S_SORT_CMP,
      S_SORT_SH,
      S_SORT_PUT,
      S_RESP
   } state_type;

   function automatic logic [ValW-1:0] sat_add(input logic [ValW-1:0] a,
                                              input logic [ValW-1:0] b);
      logic [ValW:0] s;
      begin
         s = {a[ValW-1], a} + {b[ValW-1], b};
         if (s[ValW] != s[ValW-1])
            sat_add = s[ValW] ? {1'b1, {(ValW-1){1'b0}}} : {1'b0, {(ValW-1){1'b1}}};
         else
            sat_add = s[ValW-1:0];
      end
   endfunction

endpackage

// ===== design/srsa_mem.sv =====
module srsa_mem #(
   parameter int Depth = 16384,
   parameter int Width = 42
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/sparse_row_store_accumulate_top.sv =====
// Sparse matrix store: each row holds up to ROW_CAPACITY (column, value)
// pairs in one single-port-read, single-port-write entry memory, plus a
// fill-count memory per row. Opcodes: insert, insert-add (saturating),
// read, compress (stable sort of one row by column). Every request beat
// yields exactly one response beat. After reset a clearing pass writes
// zero to every row fill count before the first request is taken. An
// out-of-bounds request goes straight to the response state. For
// insert/add/read the entry scan reads one pair per cycle from the entry
// memory and stops at the first match; compress runs an insertion sort
// that moves one pair per memory access. One request is worked on at a
// time, and the next one is taken in the cycle after the response
// register loads. A waiting response does not block the next request;
// only a finished result that finds the response register still occupied
// holds in the response state until the register drains.
module sparse_row_store_accumulate_top #(
   parameter int MaxRows = srsa_pkg::MaxRowsDef,
   parameter int MaxCols = srsa_pkg::MaxColsDef,
   parameter int RowCap  = srsa_pkg::RowCapDef
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_opcode,
   input  logic [srsa_pkg::RowW-1:0] req_row_index,
   input  logic [srsa_pkg::ColW-1:0] req_col_index,
   input  logic signed [srsa_pkg::ValW-1:0] req_entry_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [srsa_pkg::ValW-1:0] rsp_read_value,
   output logic                      rsp_found,
   output logic [1:0]                rsp_status,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [srsa_pkg::CfgW-1:0] csr_write_data
);
   import srsa_pkg::*;

   localparam int RA  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
   localparam int KA  = $clog2(RowCap);
   localparam int NW  = $clog2(RowCap + 1);
   localparam int EA  = RA + KA;
   localparam int EW  = ColW + ValW;
   localparam int LW  = $clog2(((MaxRows > MaxCols) ? MaxRows : MaxCols) + 1);

   // Configuration registers
   logic [CfgW-1:0] rows_ff, cols_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CfgW'(1024);
         cols_ff <= CfgW'(1024);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ROWS) rows_ff <= csr_write_data;
         else                       cols_ff <= csr_write_data;
      end
   end

   // Effective limits: min(register, parameter)
   logic [LW-1:0] row_lim, col_lim;
   assign row_lim = (LW'(rows_ff) < LW'(MaxRows)) ? LW'(rows_ff) : LW'(MaxRows);
   assign col_lim = (LW'(cols_ff) < LW'(MaxCols)) ? LW'(cols_ff) : LW'(MaxCols);

   state_type state_ff, state_in;

   // Captured request
   op_type        op_ff;
   logic [RA-1:0] row_ff;
   logic [ColW-1:0] col_ff;
   logic [ValW-1:0] val_ff;
   logic [NW-1:0] n_ff, n_in;
   logic [NW-1:0] k_ff, k_in;       // scan / sort outer index
   logic [NW-1:0] m_ff, m_in;       // sort inner index
   logic          hit_ff, hit_in;
   logic [KA-1:0] hitk_ff, hitk_in;
   logic [ValW-1:0] hitv_ff, hitv_in;
   logic [ColW-1:0] cc_ff, cc_in;   // sort carried pair
   logic [ValW-1:0] cv_ff, cv_in;
   logic [RA-1:0] clr_ff;
   logic          bad_ff;

   // Response register
   logic            rvalid_ff;
   logic [ValW-1:0] rval_ff;
   logic            rfnd_ff;
   logic [1:0]      rst_ff;

   // Memories
   logic          e_we;
   logic [EA-1:0] e_wa, e_ra;
   logic [EW-1:0] e_wd, e_rd;
   logic          f_we;
   logic [RA-1:0] f_wa, f_ra;
   logic [NW-1:0] f_wd, f_rd;

   srsa_mem #(.Depth(MaxRows * RowCap), .Width(EW)) u_entries (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));

   srsa_mem #(.Depth(MaxRows), .Width(NW)) u_fill (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));

   logic [ColW-1:0] rd_col;
   logic [ValW-1:0] rd_val;
   assign rd_col = e_rd[EW-1:ValW];
   assign rd_val = e_rd[ValW-1:0];

   logic take;
   assign req_ready = (state_ff == S_IDLE);
   assign take      = req_valid && req_ready;

   // Load the response register once it is empty or drains this cycle
   logic rsp_load;
   assign rsp_load = (state_ff == S_RESP) && (!rvalid_ff || rsp_ready);

   logic bad_req;
   assign bad_req = (LW'(req_row_index) >= row_lim) ||
                    ((req_opcode == OP_INSERT || req_opcode == OP_ADD) &&
                     (LW'(req_col_index) >= col_lim));

   logic [NW-1:0] n_sat;
   assign n_sat = (f_rd > NW'(RowCap)) ? NW'(RowCap) : f_rd;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_FILL:     if (clr_ff == RA'(MaxRows - 1)) state_in = S_IDLE;
         S_IDLE:     if (take) state_in = bad_req ? S_RESP : S_WAIT;
         S_WAIT:     state_in = (op_ff == OP_SORT) ? S_SORT_LD : S_SCAN;
         S_SCAN:     if (k_ff >= n_ff || hit_ff) state_in = S_UPD;
         S_UPD:      state_in = S_RESP;
         S_SORT_LD:  state_in = (k_ff >= n_ff) ? S_RESP : S_SORT_CMP;
         S_SORT_CMP: state_in = S_SORT_SH;
         S_SORT_SH:  state_in = (m_ff == '0 || !(rd_col > cc_ff)) ? S_SORT_PUT
                                                                 : S_SORT_CMP;
         S_SORT_PUT: state_in = S_SORT_LD;
         S_RESP:     if (rsp_load) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control
   logic [ValW-1:0] upd_val;
   assign upd_val = (op_ff == OP_INSERT) ? val_ff : sat_add(hitv_ff, val_ff);

   always_comb begin
      n_in = n_ff; k_in = k_ff; m_in = m_ff;
      hit_in = hit_ff; hitk_in = hitk_ff; hitv_in = hitv_ff;
      cc_in = cc_ff; cv_in = cv_ff;
      e_we = 1'b0; e_wa = {row_ff, KA'(0)}; e_wd = '0;
      e_ra = {row_ff, k_ff[KA-1:0]};
      f_we = 1'b0; f_wa = row_ff; f_wd = '0;
      f_ra = req_row_index[RA-1:0];
      case (state_ff)
         S_FILL: begin
            f_we = 1'b1; f_wa = clr_ff;
         end
         S_IDLE: begin
            k_in = '0; hit_in = 1'b0;
            e_ra = {req_row_index[RA-1:0], KA'(0)};
         end
         S_WAIT: begin
            // fill count arrives; entry 0 read issued here
            n_in = n_sat;
            k_in = (op_ff == OP_SORT) ? NW'(1) : '0;
            e_ra = {row_ff, KA'(0)};
         end
         S_SCAN: begin
            // e_rd holds entry k_ff; issue k_ff+1 while still scanning
            if (k_ff < n_ff && rd_col == col_ff) begin
               hit_in = 1'b1; hitk_in = k_ff[KA-1:0]; hitv_in = rd_val;
            end else if (!hit_ff && k_ff < n_ff) begin
               k_in = k_ff + NW'(1);
            end
            e_ra = {row_ff, k_in[KA-1:0]};
         end
         S_UPD: begin
            if (op_ff != OP_READ) begin
               if (hit_ff) begin
                  e_we = 1'b1; e_wa = {row_ff, hitk_ff}; e_wd = {col_ff, upd_val};
               end else if (n_ff < NW'(RowCap)) begin
                  e_we = 1'b1; e_wa = {row_ff, n_ff[KA-1:0]}; e_wd = {col_ff, val_ff};
                  f_we = 1'b1; f_wd = n_ff + NW'(1);
               end
            end
         end
         S_SORT_LD: begin
            // read pair k to carry
            e_ra = {row_ff, k_ff[KA-1:0]};
            m_in = k_ff;
         end
         S_SORT_CMP: begin
            cc_in = (m_ff == k_ff) ? rd_col : cc_ff;
            cv_in = (m_ff == k_ff) ? rd_val : cv_ff;
            e_ra = {row_ff, KA'(m_ff - NW'(1))};
         end
         S_SORT_SH: begin
            if (m_ff != '0 && rd_col > cc_ff) begin
               e_we = 1'b1; e_wa = {row_ff, m_ff[KA-1:0]}; e_wd = e_rd;
               m_in = m_ff - NW'(1);
            end
         end
         S_SORT_PUT: begin
            e_we = 1'b1; e_wa = {row_ff, m_ff[KA-1:0]}; e_wd = {cc_ff, cv_ff};
            k_in = k_ff + NW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_FILL;
         clr_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_FILL) clr_ff <= clr_ff + RA'(1);
         if (rsp_load)       rvalid_ff <= 1'b1;
         else if (rsp_ready) rvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; k_ff <= k_in; m_ff <= m_in;
      hit_ff <= hit_in; hitk_ff <= hitk_in; hitv_ff <= hitv_in;
      cc_ff <= cc_in; cv_ff <= cv_in;
      if (take) begin
         op_ff  <= op_type'(req_opcode);
         row_ff <= req_row_index[RA-1:0];
         col_ff <= req_col_index;
         val_ff <= req_entry_value;
         bad_ff <= bad_req;
      end
      if (rsp_load) begin
         // assemble the response beat
         if (bad_ff) begin
            rval_ff <= '0; rfnd_ff <= 1'b0; rst_ff <= ST_BOUNDS;
         end else if (op_ff == OP_SORT) begin
            rval_ff <= '0; rfnd_ff <= 1'b0; rst_ff <= ST_OK;
         end else begin
            rval_ff <= (op_ff == OP_READ && hit_ff) ? hitv_ff : '0;
            rfnd_ff <= hit_ff;
            rst_ff  <= (op_ff != OP_READ && !hit_ff && n_ff >= NW'(RowCap))
                       ? ST_FULL : ST_OK;
         end
      end
   end

   assign rsp_valid      = rvalid_ff;
   assign rsp_read_value = rval_ff;
   assign rsp_found      = rfnd_ff;
   assign rsp_status     = rst_ff;
endmodule

// ===== design/srsa_checker.sv =====
`include "assert_macros.svh"
module srsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_value,
   input logic        rsp_found,
   input logic [1:0]  rsp_status
);
   import srsa_pkg::*;
   `CHK_IMPL(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3, "bad status code")
   `CHK_IMPL(a_err_no_found, clock, reset, rsp_valid && rsp_status != ST_OK, !rsp_found && rsp_read_value == '0, "error beat carries data")
   `CHK_IMPL(a_notfound_zero, clock, reset, rsp_valid && !rsp_found, rsp_read_value == '0, "value without match")
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value), "response dropped")
   `CHK_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid, "request withdrawn")
endmodule

bind sparse_row_store_accumulate_top srsa_checker u_srsa_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_value(rsp_read_value),
   .rsp_found(rsp_found), .rsp_status(rsp_status));
